// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the quarantine FIFO block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QFBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define QFBB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qfbb_pkg.sv =====
// ----------------------------------------------------------------------------
// qfbb_pkg
// Types, widths, constants and the footprint function of the quarantine FIFO.
// ----------------------------------------------------------------------------
package qfbb_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  // Redzone granule; it must be a power of two, since the footprint rounds
  // down by masking.
  localparam int REDZONE_BYTES   = 32;
  localparam int RZ_LOG2         = $clog2(REDZONE_BYTES);

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 24;
  localparam int FP_W    = 25;
  localparam int BUDGET_W = 32;
  localparam int TOTAL_W = 33;
  localparam int COUNT_W = 6;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(10 * 1024 * 1024);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BUDGET = 2'd0,
    KIND_FORCED = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FORCE,
    S_PUSH,
    S_EVRD,
    S_EV,
    S_DONE
  } state_t;

  // One quarantine entry as stored in the memory.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [FP_W-1:0]   fp;
  } entry_t;

  // Padded footprint: size plus two redzones, rounded up to the granule.
  function automatic logic [FP_W-1:0] footprint(input logic [SIZE_W-1:0] size);
    logic [FP_W-1:0] sum;
    sum = FP_W'(size) + FP_W'(3 * REDZONE_BYTES - 1);
    return {sum[FP_W-1:RZ_LOG2], {RZ_LOG2{1'b0}}};
  endfunction

endpackage

// ===== sv/qfbb_store.sv =====
// ----------------------------------------------------------------------------
// qfbb_store
// Entry memory of the quarantine: one write port, one read port, and a
// registered read.
// ----------------------------------------------------------------------------
module qfbb_store import qfbb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/quarantine_fifo_byte_budget.sv =====
// ----------------------------------------------------------------------------
// quarantine_fifo_byte_budget
// Freed-block quarantine FIFO that evicts the oldest blocks to stay within a
// configurable byte budget.
// ----------------------------------------------------------------------------
// Each input word is one freed block. Its padded footprint is appended to the
// FIFO and added to the held total; the block then reports one word per
// evicted block (a forced eviction first when the queue was full, then budget
// evictions oldest first) and closes with a done word that has last set.
// Sequence, with no stall on the result side: a block that causes no budget
// eviction is accepted, then pushed together with its done word. A full
// queue adds a forced eviction state before the push. When the push exceeds
// the budget, the push cycle sends no word; the budget evictions then follow
// back to back, since the entry memory is read one entry ahead, and the done
// word follows in a state of its own. When the queue was empty before the
// push, an extra state rereads the just written entry through the memory's
// registered read port. The queue needs no clearing after reset.
// The budget may be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quarantine_fifo_byte_budget import qfbb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input word channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADDR_W-1:0]   in_block_address,
  input  logic [SIZE_W-1:0]   in_user_size,
  // Result word channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [ADDR_W-1:0]   out_evicted_address,
  output logic [FP_W-1:0]     out_evicted_bytes,
  output logic [TOTAL_W-1:0]  out_held_bytes,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic                out_last,
  // Budget register write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_budget_bytes
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [BUDGET_W-1:0]  budget_r;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [FP_W-1:0]      fp_r, fp_nxt;

  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [FP_W-1:0]      out_bytes_r, out_bytes_nxt;
  logic [TOTAL_W-1:0]   out_held_r, out_held_nxt;
  logic [OCC_W-1:0]     out_count_r, out_count_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 wr_en;
  logic [IDX_W-1:0]     rd_idx;
  entry_t               wr_data;
  entry_t               rd_data;

  logic                 out_free;
  logic                 emit;
  logic [TOTAL_W-1:0]   total_sub;
  logic [TOTAL_W-1:0]   total_sum;
  logic [TOTAL_W-1:0]   budget_ext;
  logic [IDX_W-1:0]     head_inc;
  logic [IDX_W-1:0]     tail_inc;

  // Entry memory.
  qfbb_store #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (tail_r),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Ring pointer increments and shared arithmetic.
  assign head_inc   = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign budget_ext = TOTAL_W'(budget_r);
  assign total_sum  = total_r + TOTAL_W'(fp_r);
  assign total_sub  = (total_r >= TOTAL_W'(rd_data.fp)) ?
                      total_r - TOTAL_W'(rd_data.fp) : '0;
  assign out_free   = !out_valid_r || !out_stall;
  assign wr_data    = '{addr: addr_r, fp: fp_r};

  // Handshake outputs.
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer: next state, memory control and result word.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    total_nxt     = total_r;
    addr_nxt      = addr_r;
    fp_nxt        = fp_r;
    wr_en         = 1'b0;
    rd_idx        = head_r;
    emit          = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_bytes_nxt = out_bytes_r;
    out_held_nxt  = out_held_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt  = in_block_address;
          fp_nxt    = footprint(in_user_size);
          state_nxt = (occ_r == FULL_OCC) ? S_FORCE : S_PUSH;
        end
      end

      S_FORCE: begin
        // The head entry was read during the accept cycle.
        if (out_free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_FORCED;
          out_addr_nxt  = rd_data.addr;
          out_bytes_nxt = rd_data.fp;
          out_held_nxt  = total_sub;
          out_count_nxt = occ_r - 1'b1;
          out_last_nxt  = 1'b0;
          head_nxt      = head_inc;
          occ_nxt       = occ_r - 1'b1;
          total_nxt     = total_sub;
          rd_idx        = head_inc;
          state_nxt     = S_PUSH;
        end
      end

      S_PUSH: begin
        wr_en     = 1'b1;
        tail_nxt  = tail_inc;
        occ_nxt   = occ_r + 1'b1;
        total_nxt = total_sum;
        if (total_sum > budget_ext) begin
          // An empty queue means the head is the entry being written now.
          state_nxt = (occ_r == '0) ? S_EVRD : S_EV;
        end else if (out_free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_addr_nxt  = '0;
          out_bytes_nxt = '0;
          out_held_nxt  = total_sum;
          out_count_nxt = occ_r + 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_EVRD: begin
        state_nxt = S_EV;
      end

      S_EV: begin
        if (out_free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_BUDGET;
          out_addr_nxt  = rd_data.addr;
          out_bytes_nxt = rd_data.fp;
          out_held_nxt  = total_sub;
          out_count_nxt = occ_r - 1'b1;
          out_last_nxt  = 1'b0;
          head_nxt      = head_inc;
          occ_nxt       = occ_r - 1'b1;
          total_nxt     = total_sub;
          rd_idx        = head_inc;
          // Keep going while the remaining total still tops the budget and an entry is left.
          if ((total_r > budget_ext + TOTAL_W'(rd_data.fp)) && (occ_r > OCC_W'(1))) begin
            state_nxt = S_EV;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_addr_nxt  = '0;
          out_bytes_nxt = '0;
          out_held_nxt  = total_r;
          out_count_nxt = occ_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      total_r     <= '0;
      budget_r    <= BUDGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        budget_r <= cfg_budget_bytes;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    fp_r        <= fp_nxt;
    out_kind_r  <= out_kind_nxt;
    out_addr_r  <= out_addr_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_held_r  <= out_held_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Result word ports.
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_evicted_address = out_addr_r;
  assign out_evicted_bytes   = out_bytes_r;
  assign out_held_bytes      = out_held_r;
  assign out_entry_count     = COUNT_W'(out_count_r);
  assign out_last            = out_last_r;

  // Assertions.
  `QFBB_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_r <= FULL_OCC, "occupancy above queue depth")
  `QFBB_ASSERT_IMP(a_empty_zero, clk, rst_n, occ_r == '0, total_r == '0, "empty queue holds bytes")
  `QFBB_ASSERT_IMP(a_force_full, clk, rst_n, state_r == S_FORCE, occ_r == FULL_OCC, "forced eviction without full queue")
  `QFBB_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE, "accepted word left sequencer idle")

endmodule
